FILE: rtl/udp_fcp_pkg.sv
// udp_fcp_pkg: types, protocol constants and checksum helpers for the
// ethernet/ipv4/udp checksum parser; no dependencies
package udp_fcp_pkg;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [3:0]  IP_VERSION4    = 4'h4;
    localparam logic [7:0]  PROTO_UDP      = 8'h11;
    localparam logic [15:0] UDP_HDR_LEN    = 16'd8;
    localparam logic [15:0] CSUM_ALL_ONES  = 16'hFFFF;

    // byte offsets from the frame start, 20-byte ipv4 header without options
    localparam int unsigned IP_HDR_BYTES   = 20;
    localparam int unsigned IP_START       = 14;
    localparam int unsigned UDP_START      = IP_START + IP_HDR_BYTES;
    localparam logic [15:0] OFF_TYPE_HI    = 16'd12;
    localparam logic [15:0] OFF_TYPE_LO    = 16'd13;
    localparam logic [15:0] OFF_VERSION    = 16'(IP_START);
    localparam logic [15:0] OFF_PROTO      = 16'(IP_START + 9);
    localparam logic [15:0] OFF_SRC_ADDR   = 16'(IP_START + 12);
    localparam logic [15:0] OFF_ULEN_LO    = 16'(UDP_START + 5);
    localparam logic [15:0] OFF_CSUM_LO    = 16'(UDP_START + 7);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PAYLOAD
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_CSUM_BAD  = 3'd1,
        ST_NOT_IPV4  = 3'd2,
        ST_BAD_VER   = 3'd3,
        ST_NOT_UDP   = 3'd4,
        ST_BAD_LEN   = 3'd5
    } t_status;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        t_status    status;
    } t_result;

    // one's-complement add with end-around carry
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] w);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, w};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    function automatic t_status csum_verdict(input logic [15:0] acc, input logic [15:0] rx);
        logic [15:0] c;
        c = ~acc;
        if (rx == 16'd0 || rx == c || (c == 16'd0 && rx == CSUM_ALL_ONES)) begin
            return ST_OK;
        end
        return ST_CSUM_BAD;
    endfunction

endpackage

FILE: rtl/udp_fcp_parse.sv
// udp_fcp_parse: input register, header/payload parse state and checksum
// accumulator; produces at most one result item per byte; uses udp_fcp_pkg
module udp_fcp_parse (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_frame_byte,
    input  logic                 i_frame_start,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output udp_fcp_pkg::t_result o_res
);
    import udp_fcp_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_start;

    t_phase      r_phase,  n_phase,  c_phase;
    logic [15:0] r_offset, n_offset, c_offset;
    logic [15:0] r_acc,    n_acc,    c_acc;
    logic [15:0] r_ulen,   n_ulen,   c_ulen;
    logic [15:0] r_rx,     n_rx,     c_rx;
    logic [7:0]  r_held,   n_held,   c_held;
    logic        r_odd,    n_odd,    c_odd;

    logic        w_fire;
    logic [15:0] w_word;
    logic        w_emit;
    logic        w_last;
    logic [7:0]  w_byte;
    t_status     w_status;

    assign w_fire  = r_in_valid && i_res_ready;
    assign o_ready = !r_in_valid || w_fire;

    // frame start wipes the packet state before the byte is parsed
    always_comb begin
        c_phase  = r_in_start ? PH_HEADER : r_phase;
        c_offset = r_in_start ? 16'd0 : r_offset;
        c_acc    = r_in_start ? 16'd0 : r_acc;
        c_ulen   = r_in_start ? 16'd0 : r_ulen;
        c_rx     = r_in_start ? 16'd0 : r_rx;
        c_held   = r_in_start ? 8'd0  : r_held;
        c_odd    = r_in_start ? 1'b0  : r_odd;
    end

    assign w_word = {c_held, r_in_byte};

    // next state
    always_comb begin
        logic [15:0] v_acc;
        n_phase  = c_phase;
        n_offset = c_offset;
        n_acc    = c_acc;
        n_ulen   = c_ulen;
        n_rx     = c_rx;
        n_held   = c_held;
        n_odd    = c_odd;
        w_emit   = 1'b0;
        w_last   = 1'b0;
        w_byte   = 8'd0;
        w_status = ST_OK;
        v_acc    = c_acc;
        case (c_phase)
            PH_HEADER: begin
                n_offset = c_offset + 16'd1;
                if (c_offset == OFF_TYPE_HI) begin
                    n_held = r_in_byte;
                end else if (c_offset == OFF_TYPE_LO) begin
                    if (w_word != ETHERTYPE_IPV4) begin
                        n_phase  = PH_IDLE;
                        w_emit   = 1'b1;
                        w_last   = 1'b1;
                        w_status = ST_NOT_IPV4;
                    end
                end else if (c_offset == OFF_VERSION) begin
                    if (r_in_byte[7:4] != IP_VERSION4) begin
                        n_phase  = PH_IDLE;
                        w_emit   = 1'b1;
                        w_last   = 1'b1;
                        w_status = ST_BAD_VER;
                    end
                end else if (c_offset == OFF_PROTO) begin
                    if (r_in_byte != PROTO_UDP) begin
                        n_phase  = PH_IDLE;
                        w_emit   = 1'b1;
                        w_last   = 1'b1;
                        w_status = ST_NOT_UDP;
                    end else begin
                        n_acc = ones_add(c_acc, {8'd0, PROTO_UDP});
                    end
                end else if (c_offset inside {[OFF_SRC_ADDR:OFF_CSUM_LO]}) begin
                    if (!c_offset[0]) begin
                        n_held = r_in_byte;
                    end else if (c_offset == OFF_ULEN_LO) begin
                        // length counts in the pseudo-header and in the udp header
                        n_ulen = w_word;
                        if (w_word < UDP_HDR_LEN) begin
                            n_phase  = PH_IDLE;
                            w_emit   = 1'b1;
                            w_last   = 1'b1;
                            w_status = ST_BAD_LEN;
                        end else begin
                            n_acc = ones_add(ones_add(c_acc, w_word), w_word);
                        end
                    end else if (c_offset == OFF_CSUM_LO) begin
                        n_rx = w_word;
                        if (c_ulen == UDP_HDR_LEN) begin
                            n_phase  = PH_IDLE;
                            w_emit   = 1'b1;
                            w_last   = 1'b1;
                            w_status = csum_verdict(c_acc, w_word);
                        end else begin
                            n_phase  = PH_PAYLOAD;
                            n_offset = c_ulen - UDP_HDR_LEN;
                            n_odd    = 1'b0;
                        end
                    end else begin
                        n_acc = ones_add(c_acc, w_word);
                    end
                end
            end
            PH_PAYLOAD: begin
                if (!c_odd) begin
                    n_held = r_in_byte;
                    // odd final byte padded with a zero low byte
                    if (c_offset == 16'd1) begin
                        v_acc = ones_add(c_acc, {r_in_byte, 8'd0});
                    end
                end else begin
                    v_acc = ones_add(c_acc, w_word);
                end
                n_acc    = v_acc;
                n_odd    = !c_odd;
                n_offset = c_offset - 16'd1;
                w_emit   = 1'b1;
                w_byte   = r_in_byte;
                if (c_offset == 16'd1) begin
                    n_phase  = PH_IDLE;
                    w_last   = 1'b1;
                    w_status = csum_verdict(v_acc, c_rx);
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_res_valid     = w_fire && w_emit;
        o_res.out_byte  = w_byte;
        o_res.out_last  = w_last;
        o_res.status    = w_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_IDLE;
            r_offset   <= 16'd0;
            r_acc      <= 16'd0;
            r_ulen     <= 16'd0;
            r_rx       <= 16'd0;
            r_held     <= 8'd0;
            r_odd      <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_fire) begin
                r_phase  <= n_phase;
                r_offset <= n_offset;
                r_acc    <= n_acc;
                r_ulen   <= n_ulen;
                r_rx     <= n_rx;
                r_held   <= n_held;
                r_odd    <= n_odd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte  <= i_frame_byte;
            r_in_start <= i_frame_start;
        end
    end

endmodule

FILE: rtl/udp_fcp_skid.sv
// udp_fcp_skid: result register with one skid entry, so the parser can hand
// over one more item after the receiver stalls; uses udp_fcp_pkg
module udp_fcp_skid (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  udp_fcp_pkg::t_result i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output udp_fcp_pkg::t_result o_data
);
    import udp_fcp_pkg::*;

    logic    r_out_valid,  n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out,        n_out;
    t_result r_skid,       n_skid;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = i_data;
                n_out_valid = i_valid;
            end
        end else if (i_valid && !r_skid_valid) begin
            // receiver stalled: park the item
            n_skid       = i_data;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule

FILE: rtl/udp_frame_checksum_parser.sv
// udp_frame_checksum_parser: top level, parser core plus result skid stage
// depends on udp_fcp_pkg, udp_fcp_parse, udp_fcp_skid
//
// Ethernet frame bytes enter on i_valid/o_ready with i_frame_byte, and
// i_frame_start high on the first byte of each frame. For an ipv4/udp
// frame every udp payload byte leaves on o_valid/i_ready as o_out_byte;
// the last one has o_out_last high and o_status ok or checksum mismatch.
// A frame with empty payload gives one status-only item (byte 0, last 1),
// and a header rejection (ethertype, version, protocol, udp length) gives
// one such item with its code, after which bytes are ignored until the
// next frame start. Bytes before a frame start or after the payload
// (padding, fcs) give nothing.
// Throughput: one byte per cycle while the result path is not stalled; the
// one's-complement add in the parser is combinational. A byte is held in the
// input register and its result in the result register before it is shown.
// When the receiver stalls, one more item parks in the skid entry and
// o_ready then drops until the stall clears; no item is lost.
// Reset (synchronous, active low) empties both stages and returns the
// parser to waiting for a frame start.
module udp_frame_checksum_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_frame_byte,
    input  logic       i_frame_start,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_last,
    output logic [2:0] o_status
);
    import udp_fcp_pkg::*;

    logic    w_res_valid;
    logic    w_res_ready;
    t_result w_res;
    t_result w_out;

    udp_fcp_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_frame_byte (i_frame_byte),
        .i_frame_start(i_frame_start),
        .o_res_valid  (w_res_valid),
        .i_res_ready  (w_res_ready),
        .o_res        (w_res)
    );

    udp_fcp_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_res_valid),
        .o_ready (w_res_ready),
        .i_data  (w_res),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (w_out)
    );

    assign o_out_byte = w_out.out_byte;
    assign o_out_last = w_out.out_last;
    assign o_status   = w_out.status;

`ifndef ASSERT_OFF
    // input side can only back up when the output holds an item
    a_stall_needs_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with no result pending");

    a_status_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out_last) |-> (o_status == ST_OK))
        else $error("status on a non-final item");

    a_reject_is_status_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_NOT_IPV4 || o_status == ST_BAD_VER ||
                     o_status == ST_NOT_UDP || o_status == ST_BAD_LEN))
        |-> (o_out_last && o_out_byte == 8'd0))
        else $error("header rejection carries payload");
`endif

endmodule

FILE: bench/udp_fcp_checker.sv
`timescale 1ns / 100ps
// udp_fcp_checker: watches both channels of udp_frame_checksum_parser, predicts
// every result item from the accepted frame bytes and compares them in order
// depends on udp_fcp_pkg for the status and phase types and protocol constants
module udp_fcp_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_frame_byte,
    input  logic       i_frame_start,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_byte,
    input  logic       i_out_last,
    input  logic [2:0] i_status,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked
);
    import udp_fcp_pkg::*;

    t_result     expected_q[$];
    t_result     oldest;

    t_phase      parse_ph;
    logic [15:0] offset_left;
    logic [15:0] csum_acc;
    logic [15:0] udp_len;
    logic [15:0] rx_csum;
    logic [7:0]  held_byte;

    function automatic logic [15:0] csum_fold(input logic [15:0] a, input logic [15:0] w);
        logic [16:0] t;
        t = {1'b0, a} + {1'b0, w};
        return t[15:0] + {15'd0, t[16]};
    endfunction

    // zero means no checksum sent; all-ones stands for a computed zero
    function automatic t_status checksum_status();
        logic [15:0] computed;
        logic        ok;
        computed = ~csum_acc;
        ok = (rx_csum == 16'd0) || (rx_csum == computed) ||
             (computed == 16'd0 && rx_csum == CSUM_ALL_ONES);
        return ok ? ST_OK : ST_CSUM_BAD;
    endfunction

    task automatic predict_byte(input logic [7:0] b, input logic start);
        logic [15:0] off;
        logic [15:0] word;
        logic [15:0] idx;
        t_result     r;
        logic        hit;
        hit        = 1'b0;
        r.out_byte = 8'h00;
        r.out_last = 1'b0;
        r.status   = ST_OK;
        if (start) begin
            parse_ph    = PH_HEADER;
            offset_left = 16'd0;
            csum_acc    = 16'd0;
            udp_len     = 16'd0;
            rx_csum     = 16'd0;
            held_byte   = 8'h00;
        end
        if (parse_ph == PH_HEADER) begin
            off         = offset_left;
            word        = {held_byte, b};
            offset_left = offset_left + 16'd1;
            if (off == OFF_TYPE_HI) begin
                held_byte = b;
            end else if (off == OFF_TYPE_LO) begin
                if (word != ETHERTYPE_IPV4) begin
                    hit      = 1'b1;
                    r.status = ST_NOT_IPV4;
                end
            end else if (off == OFF_VERSION) begin
                if (b[7:4] != IP_VERSION4) begin
                    hit      = 1'b1;
                    r.status = ST_BAD_VER;
                end
            end else if (off == OFF_PROTO) begin
                if (b != PROTO_UDP) begin
                    hit      = 1'b1;
                    r.status = ST_NOT_UDP;
                end else begin
                    csum_acc = csum_fold(csum_acc, {8'h00, PROTO_UDP});
                end
            end else if (off >= OFF_SRC_ADDR && off <= OFF_CSUM_LO) begin
                if (!off[0]) begin
                    held_byte = b;
                end else if (off == OFF_ULEN_LO) begin
                    udp_len = word;
                    if (word < UDP_HDR_LEN) begin
                        hit      = 1'b1;
                        r.status = ST_BAD_LEN;
                    end else begin
                        // once for the pseudo-header, once for the udp header
                        csum_acc = csum_fold(csum_acc, word);
                        csum_acc = csum_fold(csum_acc, word);
                    end
                end else if (off == OFF_CSUM_LO) begin
                    rx_csum = word;
                    if (udp_len == UDP_HDR_LEN) begin
                        hit      = 1'b1;
                        r.status = checksum_status();
                    end else begin
                        parse_ph    = PH_PAYLOAD;
                        offset_left = udp_len - UDP_HDR_LEN;
                    end
                end else begin
                    csum_acc = csum_fold(csum_acc, word);
                end
            end
            if (hit) begin
                r.out_last = 1'b1;
                parse_ph   = PH_IDLE;
            end
        end else if (parse_ph == PH_PAYLOAD) begin
            idx = (udp_len - UDP_HDR_LEN) - offset_left;
            if (!idx[0]) begin
                held_byte = b;
                // odd final byte, padded with a zero low byte
                if (offset_left == 16'd1) begin
                    csum_acc = csum_fold(csum_acc, {b, 8'h00});
                end
            end else begin
                csum_acc = csum_fold(csum_acc, {held_byte, b});
            end
            offset_left = offset_left - 16'd1;
            hit         = 1'b1;
            r.out_byte  = b;
            if (offset_left == 16'd0) begin
                parse_ph   = PH_IDLE;
                r.out_last = 1'b1;
                r.status   = checksum_status();
            end
        end
        if (hit) begin
            expected_q.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            parse_ph     = PH_IDLE;
            offset_left  = 16'd0;
            csum_acc     = 16'd0;
            udp_len      = 16'd0;
            rx_csum      = 16'd0;
            held_byte    = 8'h00;
            o_fail_count = 0;
            o_checked    = 0;
            expected_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected item, expected none, actual byte %02h last %0b status %0d",
                             $time, i_out_byte, i_out_last, i_status);
                end else begin
                    oldest = expected_q.pop_front();
                    o_checked++;
                    if (i_out_byte !== oldest.out_byte) begin
                        o_fail_count++;
                        $display("%0t: out_byte expected %02h actual %02h",
                                 $time, oldest.out_byte, i_out_byte);
                    end
                    if (i_out_last !== oldest.out_last) begin
                        o_fail_count++;
                        $display("%0t: out_last expected %0b actual %0b",
                                 $time, oldest.out_last, i_out_last);
                    end
                    if (i_status !== oldest.status) begin
                        o_fail_count++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, oldest.status, i_status);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_byte(i_frame_byte, i_frame_start);
            end
        end
        o_pending = expected_q.size();
    end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// tb_top: builds ethernet/ipv4/udp frames with chosen checksums and header
// faults, drives them into udp_frame_checksum_parser and gives the verdict
// depends on udp_fcp_pkg, udp_frame_checksum_parser and udp_fcp_checker
module tb_top;
    import udp_fcp_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 150;
    localparam int PHASE_BYTES  = 32;

    typedef enum {
        FR_GOOD,
        FR_CSUM_BAD,
        FR_CSUM_NONE,
        FR_CSUM_ONES,
        FR_BAD_TYPE,
        FR_BAD_VER,
        FR_BAD_PROTO,
        FR_BAD_LEN
    } t_frame_kind;

    logic       i_clk;
    logic       i_rst_n       = 1'b0;
    logic       i_valid       = 1'b0;
    logic [7:0] i_frame_byte  = 8'h00;
    logic       i_frame_start = 1'b0;
    logic       i_ready       = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_out_last;
    logic [2:0] o_status;

    int fail_count;
    int pending;
    int checked;

    int   snd_idle   = 0;
    int   rcv_idle   = 0;
    logic hold_tog   = 1'b0;
    logic hold_seen;
    int   hold_left;
    int   cycle_count;
    int   bytes_sent = 0;
    int   frames_sent = 0;
    int   phase_start;

    logic [7:0] frame_q[$];

    udp_frame_checksum_parser i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_frame_byte (i_frame_byte),
        .i_frame_start(i_frame_start),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte),
        .o_out_last   (o_out_last),
        .o_status     (o_status)
    );

    udp_fcp_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_frame_byte (i_frame_byte),
        .i_frame_start(i_frame_start),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_byte   (o_out_byte),
        .i_out_last   (o_out_last),
        .i_status     (o_status),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d items still expected", cycle_count, pending);
        $display("TEST FAILED");
        $finish;
    end

    // receiver: random back-pressure, plus a long hold-off on request
    initial begin
        hold_seen = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_tog != hold_seen) begin
                hold_seen = hold_tog;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= rcv_idle);
            end
        end
    end

    function automatic logic [15:0] sum16(input logic [15:0] a, input logic [15:0] w);
        logic [16:0] t;
        t = {1'b0, a} + {1'b0, w};
        return t[15:0] + {15'd0, t[16]};
    endfunction

    // one's-complement sum over pseudo-header, udp header words and payload
    function automatic logic [15:0] frame_sum();
        logic [15:0] s;
        int          plen;
        s = 16'h0000;
        for (int i = 26; i < 38; i += 2) begin
            s = sum16(s, {frame_q[i], frame_q[i+1]});
        end
        s = sum16(s, {8'h00, PROTO_UDP});
        s = sum16(s, {frame_q[38], frame_q[39]});
        s = sum16(s, {frame_q[38], frame_q[39]});
        plen = int'({frame_q[38], frame_q[39]}) - 8;
        for (int i = 0; i < plen; i += 2) begin
            s = sum16(s, {frame_q[42+i], (i + 1 < plen) ? frame_q[43+i] : 8'h00});
        end
        return s;
    endfunction

    // fill < 0 gives random payload bytes; for bad length, plen is the udp length
    task automatic build_frame(input t_frame_kind kind, input int plen, input int fill);
        logic [15:0] etype;
        logic [3:0]  ver;
        logic [7:0]  proto;
        logic [15:0] ulen;
        logic [15:0] c;
        logic [15:0] rx;
        logic [15:0] w;
        frame_q.delete();
        repeat (12) frame_q.push_back(8'($urandom));
        etype = ETHERTYPE_IPV4;
        if (kind == FR_BAD_TYPE) begin
            while (etype == ETHERTYPE_IPV4) etype = 16'($urandom);
        end
        frame_q.push_back(etype[15:8]);
        frame_q.push_back(etype[7:0]);
        ver = IP_VERSION4;
        if (kind == FR_BAD_VER) begin
            while (ver == IP_VERSION4) ver = 4'($urandom);
        end
        frame_q.push_back({ver, 4'($urandom)});
        repeat (8) frame_q.push_back(8'($urandom));
        proto = PROTO_UDP;
        if (kind == FR_BAD_PROTO) begin
            while (proto == PROTO_UDP) proto = 8'($urandom);
        end
        frame_q.push_back(proto);
        // ip header checksum, addresses and ports
        repeat (14) frame_q.push_back(8'($urandom));
        ulen = (kind == FR_BAD_LEN) ? 16'(plen) : 16'(plen) + UDP_HDR_LEN;
        frame_q.push_back(ulen[15:8]);
        frame_q.push_back(ulen[7:0]);
        frame_q.push_back(8'h00);
        frame_q.push_back(8'h00);
        if (kind == FR_BAD_LEN) begin
            repeat ($urandom_range(0, 8)) frame_q.push_back(8'($urandom));
        end else begin
            for (int i = 0; i < plen; i++) begin
                frame_q.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
            end
        end
        if (kind == FR_CSUM_ONES) begin
            // last word brings the sum to all ones, so the computed checksum is zero
            frame_q[40 + plen] = 8'h00;
            frame_q[41 + plen] = 8'h00;
            w = 16'hFFFF - frame_sum();
            frame_q[40 + plen] = w[15:8];
            frame_q[41 + plen] = w[7:0];
        end
        c = ~frame_sum();
        case (kind)
            FR_CSUM_BAD: begin
                rx = c;
                while (rx == c || rx == 16'h0000 || rx == CSUM_ALL_ONES) rx = 16'($urandom);
            end
            FR_CSUM_NONE: rx = 16'h0000;
            FR_CSUM_ONES: rx = CSUM_ALL_ONES;
            default:      rx = c;
        endcase
        frame_q[40] = rx[15:8];
        frame_q[41] = rx[7:0];
    endtask

    // entered and left just after a falling edge; valid stays high across items unless an idle gap is drawn
    task automatic send_byte(input logic [7:0] b, input logic start);
        while ($urandom_range(0, 99) < snd_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_frame_byte  <= b;
        i_frame_start <= start;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    // cut > 0 stops the frame early, so the next frame start restarts the parse
    task automatic send_frame(input int cut);
        int n;
        n = (cut > 0) ? cut : frame_q.size();
        for (int i = 0; i < n; i++) begin
            send_byte(frame_q[i], i == 0);
        end
        frames_sent++;
    endtask

    task automatic send_noise(input int n);
        repeat (n) send_byte(8'($urandom), 1'b0);
    endtask

    task automatic drain_outputs();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic random_frame();
        int          pick;
        int          plen;
        int          cut;
        t_frame_kind kind;
        pick = $urandom_range(0, 99);
        plen = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 20) : $urandom_range(21, 80);
        cut  = 0;
        if (pick < 40) begin
            kind = FR_GOOD;
        end else if (pick < 55) begin
            kind = FR_CSUM_BAD;
        end else if (pick < 62) begin
            kind = FR_CSUM_NONE;
        end else if (pick < 68) begin
            kind = FR_CSUM_ONES;
            plen = 2 * (plen / 2) + 2;
        end else if (pick < 73) begin
            kind = FR_BAD_TYPE;
        end else if (pick < 78) begin
            kind = FR_BAD_VER;
        end else if (pick < 83) begin
            kind = FR_BAD_PROTO;
        end else if (pick < 88) begin
            kind = FR_BAD_LEN;
            plen = $urandom_range(0, 7);
        end else begin
            kind = FR_GOOD;
            cut  = $urandom_range(1, 41 + plen);
        end
        build_frame(kind, plen, -1);
        send_frame(cut);
        if ($urandom_range(0, 3) == 0) begin
            send_noise($urandom_range(1, 6));
        end
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n  <= 1'b1;
        snd_idle = 20;
        rcv_idle <= 46;

        // bytes before any frame start are ignored
        send_noise(4);
        build_frame(FR_GOOD, 4, 8'h00);
        send_frame(0);
        build_frame(FR_GOOD, 5, 8'hFF);
        send_frame(0);
        build_frame(FR_CSUM_BAD, 10, -1);
        send_frame(0);
        build_frame(FR_CSUM_NONE, 3, -1);
        send_frame(0);
        build_frame(FR_CSUM_ONES, 8, -1);
        send_frame(0);
        build_frame(FR_GOOD, 0, -1);
        send_frame(0);
        build_frame(FR_CSUM_BAD, 0, -1);
        send_frame(0);
        build_frame(FR_GOOD, 1, -1);
        send_frame(0);
        build_frame(FR_BAD_TYPE, 2, -1);
        send_frame(0);
        build_frame(FR_BAD_VER, 2, -1);
        send_frame(0);
        build_frame(FR_BAD_PROTO, 2, -1);
        send_frame(0);
        build_frame(FR_BAD_LEN, 0, -1);
        send_frame(0);
        build_frame(FR_BAD_LEN, 7, -1);
        send_frame(0);
        // restart inside the header, then inside the payload
        build_frame(FR_GOOD, 12, -1);
        send_frame(30);
        build_frame(FR_GOOD, 12, -1);
        send_frame(48);
        // trailing padding and fcs after the payload
        build_frame(FR_GOOD, 2, -1);
        send_frame(0);
        send_noise(5);
        drain_outputs();

        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin
                    snd_idle = 20;
                    rcv_idle <= 46;
                end
                1: begin
                    snd_idle = 46;
                    rcv_idle <= 20;
                end
                default: begin
                    snd_idle = 0;
                    rcv_idle <= 0;
                end
            endcase
            if (p == 2) begin
                // long output stall while a packet keeps coming in
                hold_tog <= ~hold_tog;
                build_frame(FR_GOOD, 30, -1);
                send_frame(0);
            end
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) random_frame();
            drain_outputs();
        end

        repeat (8) @(negedge i_clk);
        $display("covered %0d frames, %0d bytes, %0d result items checked",
                 frames_sent, bytes_sent, checked);
        $display("good, bad, absent and all-ones checksums, header rejections, restarts, %s",
                 "padding, three idle mixes and a long output stall");
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/udp_fcp_pkg.sv
rtl/udp_fcp_parse.sv
rtl/udp_fcp_skid.sv
rtl/udp_frame_checksum_parser.sv
bench/udp_fcp_checker.sv
bench/tb_top.sv
